>>> sv/gs1_element_string_parser_core_macros.svh
// Assertion helpers for the checker file.
`ifndef GS1_ELEMENT_STRING_PARSER_CORE_MACROS_SVH
`define GS1_ELEMENT_STRING_PARSER_CORE_MACROS_SVH

// Same-cycle implication, clocked on clk and quiet while rst_n is low.
`define GSEP_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, clocked on clk and quiet while rst_n is low.
`define GSEP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

>>> sv/gsep_pkg.sv
package gsep_pkg;

  localparam logic [7:0] GS_BYTE     = 8'h1D;
  localparam logic [7:0] AIM_FLAG    = 8'h5D;  // ']'
  localparam logic [7:0] CHAR_ZERO   = 8'h30;
  localparam logic [7:0] CHAR_ONE    = 8'h31;
  localparam logic [7:0] CHAR_TWO    = 8'h32;
  localparam logic [7:0] CHAR_SEVEN  = 8'h37;
  localparam logic [7:0] CHAR_NINE   = 8'h39;

  localparam logic [4:0] MAX_VARIABLE_LEN = 5'd20;
  localparam logic [4:0] GTIN_DIGITS      = 5'd14;
  localparam logic [4:0] EXPIRY_DIGITS    = 5'd6;
  localparam int         EXP_STORE_DEPTH  = 5;
  localparam logic [11:0] YEAR_BASE       = 12'd2000;

  localparam logic [2:0] ROLE_SEPARATOR = 3'd0;
  localparam logic [2:0] ROLE_AIM       = 3'd1;
  localparam logic [2:0] ROLE_AI_CHAR   = 3'd2;
  localparam logic [2:0] ROLE_GTIN      = 3'd3;
  localparam logic [2:0] ROLE_EXPIRY    = 3'd4;
  localparam logic [2:0] ROLE_LOT       = 3'd5;
  localparam logic [2:0] ROLE_SERIAL    = 3'd6;
  localparam logic [2:0] ROLE_IGNORED   = 3'd7;

  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_TRUNC   = 3'd1;
  localparam logic [2:0] ST_FIXED   = 3'd2;
  localparam logic [2:0] ST_VAR     = 3'd3;
  localparam logic [2:0] ST_UNKNOWN = 3'd4;
  localparam logic [2:0] ST_EMPTY   = 3'd5;

  // Two decimal digits to a binary value.
  function automatic logic [6:0] dec2(input logic [3:0] hi, input logic [3:0] lo);
    logic [6:0] h;
    h = {3'b000, hi};
    return (h << 3) + (h << 1) + {3'b000, lo};
  endfunction

  function automatic logic [4:0] month_last_day(input logic [3:0] mm, input logic leap);
    logic [4:0] d;
    case (mm)
      4'd2:    d = leap ? 5'd29 : 5'd28;
      4'd4:    d = 5'd30;
      4'd6:    d = 5'd30;
      4'd9:    d = 5'd30;
      4'd11:   d = 5'd30;
      default: d = 5'd31;
    endcase
    return d;
  endfunction

endpackage

>>> sv/gs1_element_string_parser_core.sv
// GS1 element string parser.
// Input stream: one scanned byte per request on in_tdata, in_tlast on the last
// byte of a message. Output stream: one result per input byte. out_tuser holds
// the byte role; out_tdata holds the position in the field and, on the result
// that carries out_tlast, the message status and the last completed expiry
// date (day 00 resolved to the month's last day, leap years included).
// out_tvalid rises in the cycle after the input is accepted. Throughput is
// one byte per cycle: the phase update and date conversion sit between the
// input port and the single result register, and in_tready stays high while
// the result register is empty or being drained in the same cycle.
// When the receiver stalls, the result register holds and in_tready drops
// until out_tready returns; no byte is lost.
// After reset (rst_n low, synchronous) the block waits at the start of a
// message with no error and no expiry seen; the result register is empty.
// Each message end returns the parser to that start state.
module gs1_element_string_parser_core
  import gsep_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] data_byte
  input  logic        in_tlast,   // message_end
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // [4:0] position_in_field, [7:5] status,
                                  // [8] expiry_seen, [9] expiry_valid,
                                  // [21:10] expiry_year, [25:22] expiry_month,
                                  // [30:26] expiry_day, [31] zero
  output logic [2:0]  out_tuser,  // [2:0] byte_role
  output logic        out_tlast   // done_res
);

  typedef enum logic [2:0] {
    PH_START, PH_AIM, PH_IDLE, PH_AI2, PH_GTIN, PH_EXPIRY, PH_LOT, PH_SERIAL
  } phase_t;

  phase_t      phase_r, phase_nxt;
  logic [7:0]  first_r, first_nxt;
  logic [4:0]  fcnt_r, fcnt_nxt;
  logic [1:0]  aim_r, aim_nxt;
  logic [2:0]  err_r, err_nxt;
  logic        found_r, found_nxt;
  logic        expc_r, expc_nxt;

  logic [3:0]  store_r [EXP_STORE_DEPTH];
  logic        store_we;

  logic [11:0] lat_year_r, lat_year_nxt;
  logic [3:0]  lat_month_r, lat_month_nxt;
  logic [4:0]  lat_day_r, lat_day_nxt;
  logic        lat_valid_r, lat_valid_nxt;

  logic        out_valid_r;
  logic [2:0]  role_r, role_nxt;
  logic [4:0]  pos_r, pos_nxt;
  logic        last_r;
  logic [2:0]  status_r, status_nxt;
  logic        seen_r, seen_nxt;
  logic        valid_r, valid_nxt;
  logic [11:0] year_r, year_nxt;
  logic [3:0]  month_r, month_nxt;
  logic [4:0]  day_r, day_nxt;

  logic        accept;
  logic [7:0]  b;
  logic        digit;
  phase_t      eff_phase;
  logic [6:0]  yy, mm, dd;
  logic        leap;
  logic        date_ok;

  assign accept    = in_tvalid && in_tready;
  assign in_tready = !out_valid_r || out_tready;
  assign b         = in_tdata;
  assign digit     = (b >= CHAR_ZERO) && (b <= CHAR_NINE);

  // Date of a field whose sixth digit is the current byte.
  assign yy      = dec2(store_r[0], store_r[1]);
  assign mm      = dec2(store_r[2], store_r[3]);
  assign dd      = dec2(store_r[4], b[3:0]);
  assign leap    = (yy[1:0] == 2'b00);
  assign date_ok = (mm >= 7'd1) && (mm <= 7'd12) && (dd <= 7'd31);

  always_comb begin
    phase_nxt     = phase_r;
    first_nxt     = first_r;
    fcnt_nxt      = fcnt_r;
    aim_nxt       = aim_r;
    err_nxt       = err_r;
    found_nxt     = found_r;
    expc_nxt      = expc_r;
    lat_year_nxt  = lat_year_r;
    lat_month_nxt = lat_month_r;
    lat_day_nxt   = lat_day_r;
    lat_valid_nxt = lat_valid_r;
    store_we      = 1'b0;
    role_nxt      = ROLE_IGNORED;
    pos_nxt       = 5'd0;
    status_nxt    = ST_OK;
    seen_nxt      = 1'b0;
    valid_nxt     = 1'b0;
    year_nxt      = 12'd0;
    month_nxt     = 4'd0;
    day_nxt       = 5'd0;
    eff_phase     = (phase_r == PH_START) ? PH_IDLE : phase_r;

    if (err_r == ST_OK) begin
      if (phase_r == PH_START && b == AIM_FLAG) begin
        role_nxt  = ROLE_AIM;
        aim_nxt   = 2'd1;
        phase_nxt = PH_AIM;
      end else begin
        case (eff_phase)
          PH_AIM: begin
            role_nxt = ROLE_AIM;
            pos_nxt  = {3'b000, aim_r};
            aim_nxt  = aim_r + 2'd1;
            if (aim_nxt == 2'd3) begin
              phase_nxt = PH_IDLE;
            end
          end
          PH_AI2: begin
            role_nxt = ROLE_AI_CHAR;
            pos_nxt  = 5'd1;
            fcnt_nxt = 5'd0;
            if (first_r == CHAR_ZERO && b == CHAR_ONE) begin
              phase_nxt = PH_GTIN;
            end else if (first_r == CHAR_ONE && b == CHAR_SEVEN) begin
              phase_nxt = PH_EXPIRY;
            end else if (first_r == CHAR_ONE && b == CHAR_ZERO) begin
              phase_nxt = PH_LOT;
            end else if (first_r == CHAR_TWO && b == CHAR_ONE) begin
              phase_nxt = PH_SERIAL;
            end else begin
              err_nxt = ST_UNKNOWN;
            end
          end
          PH_GTIN: begin
            role_nxt = ROLE_GTIN;
            pos_nxt  = fcnt_r;
            if (!digit) begin
              err_nxt = ST_FIXED;
            end else begin
              fcnt_nxt = fcnt_r + 5'd1;
              if (fcnt_nxt >= GTIN_DIGITS) begin
                found_nxt = 1'b1;
                phase_nxt = PH_IDLE;
              end
            end
          end
          PH_EXPIRY: begin
            role_nxt = ROLE_EXPIRY;
            pos_nxt  = fcnt_r;
            if (!digit) begin
              err_nxt = ST_FIXED;
            end else begin
              store_we = (fcnt_r < 5'(EXP_STORE_DEPTH));
              fcnt_nxt = fcnt_r + 5'd1;
              if (fcnt_nxt >= EXPIRY_DIGITS) begin
                lat_year_nxt  = YEAR_BASE + {5'b00000, yy};
                lat_valid_nxt = date_ok;
                lat_month_nxt = date_ok ? mm[3:0] : 4'd0;
                lat_day_nxt   = !date_ok ? 5'd0 :
                                (dd == 7'd0) ? month_last_day(mm[3:0], leap) : dd[4:0];
                expc_nxt      = 1'b1;
                found_nxt     = 1'b1;
                phase_nxt     = PH_IDLE;
              end
            end
          end
          PH_LOT, PH_SERIAL: begin
            if (b == GS_BYTE) begin
              role_nxt = ROLE_SEPARATOR;
              if (fcnt_r == 5'd0) begin
                err_nxt = ST_VAR;
              end else begin
                found_nxt = 1'b1;
                phase_nxt = PH_IDLE;
              end
            end else begin
              role_nxt = (eff_phase == PH_LOT) ? ROLE_LOT : ROLE_SERIAL;
              pos_nxt  = fcnt_r;
              if (fcnt_r >= MAX_VARIABLE_LEN) begin
                err_nxt = ST_VAR;
              end else begin
                fcnt_nxt = fcnt_r + 5'd1;
              end
            end
          end
          default: begin
            phase_nxt = PH_IDLE;
            if (b == GS_BYTE) begin
              role_nxt = ROLE_SEPARATOR;
            end else begin
              role_nxt  = ROLE_AI_CHAR;
              first_nxt = b;
              phase_nxt = PH_AI2;
            end
          end
        endcase
      end
    end

    if (in_tlast) begin
      if (err_nxt == ST_OK) begin
        case (phase_nxt)
          PH_AIM:            err_nxt = (aim_nxt == 2'd1) ? ST_TRUNC : ST_UNKNOWN;
          PH_AI2:            err_nxt = ST_TRUNC;
          PH_GTIN, PH_EXPIRY: err_nxt = ST_FIXED;
          PH_LOT, PH_SERIAL: begin
            if (fcnt_nxt == 5'd0) begin
              err_nxt = ST_VAR;
            end else begin
              found_nxt = 1'b1;
            end
          end
          default: ;
        endcase
      end
      status_nxt = (err_nxt != ST_OK) ? err_nxt : (found_nxt ? ST_OK : ST_EMPTY);
      if (expc_nxt) begin
        seen_nxt  = 1'b1;
        valid_nxt = lat_valid_nxt;
        year_nxt  = lat_year_nxt;
        month_nxt = lat_month_nxt;
        day_nxt   = lat_day_nxt;
      end
      // back to the start of the next message
      phase_nxt = PH_START;
      first_nxt = 8'd0;
      fcnt_nxt  = 5'd0;
      aim_nxt   = 2'd0;
      err_nxt   = ST_OK;
      found_nxt = 1'b0;
      expc_nxt  = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_START;
      first_r     <= 8'd0;
      fcnt_r      <= 5'd0;
      aim_r       <= 2'd0;
      err_r       <= ST_OK;
      found_r     <= 1'b0;
      expc_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        phase_r     <= phase_nxt;
        first_r     <= first_nxt;
        fcnt_r      <= fcnt_nxt;
        aim_r       <= aim_nxt;
        err_r       <= err_nxt;
        found_r     <= found_nxt;
        expc_r      <= expc_nxt;
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload: date latch, digit store and result register.
  always_ff @(posedge clk) begin
    if (accept) begin
      lat_year_r  <= lat_year_nxt;
      lat_month_r <= lat_month_nxt;
      lat_day_r   <= lat_day_nxt;
      lat_valid_r <= lat_valid_nxt;
      role_r      <= role_nxt;
      pos_r       <= pos_nxt;
      last_r      <= in_tlast;
      status_r    <= status_nxt;
      seen_r      <= seen_nxt;
      valid_r     <= valid_nxt;
      year_r      <= year_nxt;
      month_r     <= month_nxt;
      day_r       <= day_nxt;
      if (store_we) begin
        store_r[fcnt_r[2:0]] <= b[3:0];
      end
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = role_r;
  assign out_tlast  = last_r;
  assign out_tdata  = {1'b0, day_r, month_r, year_r, valid_r, seen_r, status_r, pos_r};

endmodule

>>> sv/gsep_checker.sv
`include "gs1_element_string_parser_core_macros.svh"

module gsep_checker
  import gsep_pkg::*;
(
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [31:0] out_tdata,
  input logic [2:0]  out_tuser,
  input logic        out_tlast
);

  `GSEP_ASSERT_NEXT(a_result_follows, in_tvalid && in_tready, out_tvalid, "accepted byte gave no result")
  `GSEP_ASSERT_NEXT(a_stall_holds, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata), "stalled result changed")
  `GSEP_ASSERT_NOW(a_mid_quiet, out_tvalid && !out_tlast, out_tdata[30:5] == 26'd0, "status or date on a mid-message result")
  `GSEP_ASSERT_NOW(a_ignored_pos, out_tvalid && out_tuser == ROLE_IGNORED, out_tdata[4:0] == 5'd0, "ignored byte with nonzero position")
  `GSEP_ASSERT_NOW(a_no_expiry, out_tvalid && out_tlast && !out_tdata[8], out_tdata[30:9] == 22'd0, "date reported without an expiry field")

endmodule

bind gs1_element_string_parser_core gsep_checker u_gsep_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .out_tlast  (out_tlast)
);

>>> sim/tb.sv
module tb;
  import gsep_pkg::*;

  localparam int STALL_LIMIT = 1000;
  localparam int LONG_HOLD   = 150;
  localparam int CALM_TAIL   = 150;

  typedef enum logic [3:0] {
    PS_START, PS_AIM, PS_IDLE, PS_AI2, PS_GTIN, PS_EXPIRY, PS_LOT, PS_SERIAL
  } parse_phase_t;

  typedef struct packed {
    logic [2:0]  role;
    logic [4:0]  pos;
    logic        done;
    logic [2:0]  status;
    logic        seen;
    logic        valid;
    logic [11:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
  } parse_result_t;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } scan_byte_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = 8'h00;   // [7:0] data_byte
  logic        in_tlast = 1'b0;    // message_end
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [31:0] out_tdata;          // [4:0] position_in_field, [7:5] status,
                                   // [8] expiry_seen, [9] expiry_valid,
                                   // [21:10] expiry_year, [25:22] expiry_month,
                                   // [30:26] expiry_day
  logic [2:0]  out_tuser;          // [2:0] byte_role
  logic        out_tlast;          // done_res

  gs1_element_string_parser_core dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Parser state mirror
  parse_phase_t phase = PS_START;
  logic [7:0]   ai_first = 8'h00;
  logic [4:0]   field_cnt = 5'd0;
  logic [1:0]   aim_cnt = 2'd0;
  logic [2:0]   err_code = ST_OK;
  logic         found = 1'b0;
  logic         expiry_done = 1'b0;
  logic [3:0]   date_digits [6];
  logic [11:0]  lat_year = 12'd0;
  logic [3:0]   lat_month = 4'd0;
  logic [4:0]   lat_day = 5'd0;
  logic         lat_valid = 1'b0;

  scan_byte_t    pending [$];
  parse_result_t parse_expect [$];
  int total_bytes = 0;
  int bytes_accepted = 0;
  int results_seen = 0;
  int fail_count = 0;
  int send_gap = 0;
  int recv_hold = 0;
  int quiet_cycles = 0;
  bit pressure_done = 1'b0;

  function automatic parse_result_t parse_byte(input logic [7:0] b, input logic last);
    parse_result_t r;
    logic is_digit;
    logic taken;
    int yr, mm, dd;
    r = '0;
    r.role = ROLE_IGNORED;
    is_digit = (b >= CHAR_ZERO) && (b <= CHAR_NINE);
    taken = 1'b0;
    if (err_code == ST_OK) begin
      if (phase == PS_START) begin
        if (b == AIM_FLAG) begin
          r.role = ROLE_AIM;
          aim_cnt = 2'd1;
          phase = PS_AIM;
          taken = 1'b1;
        end else begin
          phase = PS_IDLE;
        end
      end
      if (!taken) begin
        case (phase)
          PS_AIM: begin
            r.role = ROLE_AIM;
            r.pos = {3'b000, aim_cnt};
            aim_cnt = aim_cnt + 2'd1;
            if (aim_cnt == 2'd3) phase = PS_IDLE;
          end
          PS_AI2: begin
            r.role = ROLE_AI_CHAR;
            r.pos = 5'd1;
            field_cnt = 5'd0;
            if (ai_first == CHAR_ZERO && b == CHAR_ONE) phase = PS_GTIN;
            else if (ai_first == CHAR_ONE && b == CHAR_SEVEN) phase = PS_EXPIRY;
            else if (ai_first == CHAR_ONE && b == CHAR_ZERO) phase = PS_LOT;
            else if (ai_first == CHAR_TWO && b == CHAR_ONE) phase = PS_SERIAL;
            else err_code = ST_UNKNOWN;
          end
          PS_GTIN: begin
            r.role = ROLE_GTIN;
            r.pos = field_cnt;
            if (!is_digit) begin
              err_code = ST_FIXED;
            end else begin
              field_cnt = field_cnt + 5'd1;
              if (field_cnt >= GTIN_DIGITS) begin
                found = 1'b1;
                phase = PS_IDLE;
              end
            end
          end
          PS_EXPIRY: begin
            r.role = ROLE_EXPIRY;
            r.pos = field_cnt;
            if (!is_digit) begin
              err_code = ST_FIXED;
            end else begin
              if (field_cnt < EXPIRY_DIGITS) date_digits[field_cnt[2:0]] = b[3:0];
              field_cnt = field_cnt + 5'd1;
              if (field_cnt >= EXPIRY_DIGITS) begin
                // YYMMDD, day 00 means the last day of the month
                yr = 2000 + int'(date_digits[0]) * 10 + int'(date_digits[1]);
                mm = int'(date_digits[2]) * 10 + int'(date_digits[3]);
                dd = int'(date_digits[4]) * 10 + int'(date_digits[5]);
                lat_year = 12'(yr);
                lat_valid = 1'b0;
                lat_month = 4'd0;
                lat_day = 5'd0;
                if (mm >= 1 && mm <= 12 && dd <= 31) begin
                  if (dd == 0) begin
                    case (mm)
                      2: dd = ((yr % 4 == 0) && ((yr % 100 != 0) || (yr % 400 == 0))) ? 29 : 28;
                      4, 6, 9, 11: dd = 30;
                      default: dd = 31;
                    endcase
                  end
                  lat_valid = 1'b1;
                  lat_month = 4'(mm);
                  lat_day = 5'(dd);
                end
                expiry_done = 1'b1;
                found = 1'b1;
                phase = PS_IDLE;
              end
            end
          end
          PS_LOT, PS_SERIAL: begin
            if (b == GS_BYTE) begin
              r.role = ROLE_SEPARATOR;
              if (field_cnt == 5'd0) begin
                err_code = ST_VAR;
              end else begin
                found = 1'b1;
                phase = PS_IDLE;
              end
            end else begin
              r.role = (phase == PS_LOT) ? ROLE_LOT : ROLE_SERIAL;
              r.pos = field_cnt;
              if (field_cnt >= MAX_VARIABLE_LEN) err_code = ST_VAR;
              else field_cnt = field_cnt + 5'd1;
            end
          end
          default: begin
            phase = PS_IDLE;
            if (b == GS_BYTE) begin
              r.role = ROLE_SEPARATOR;
            end else begin
              r.role = ROLE_AI_CHAR;
              ai_first = b;
              phase = PS_AI2;
            end
          end
        endcase
      end
    end

    if (last) begin
      if (err_code == ST_OK) begin
        case (phase)
          PS_AIM:              err_code = (aim_cnt == 2'd1) ? ST_TRUNC : ST_UNKNOWN;
          PS_AI2:              err_code = ST_TRUNC;
          PS_GTIN, PS_EXPIRY:  err_code = ST_FIXED;
          PS_LOT, PS_SERIAL: begin
            if (field_cnt == 5'd0) err_code = ST_VAR;
            else found = 1'b1;
          end
          default: ;
        endcase
      end
      r.done = 1'b1;
      r.status = (err_code != ST_OK) ? err_code : (found ? ST_OK : ST_EMPTY);
      if (expiry_done) begin
        r.seen = 1'b1;
        r.valid = lat_valid;
        r.year = lat_year;
        r.month = lat_month;
        r.day = lat_day;
      end
      // back to the start of a message
      phase = PS_START;
      ai_first = 8'h00;
      field_cnt = 5'd0;
      aim_cnt = 2'd0;
      err_code = ST_OK;
      found = 1'b0;
      expiry_done = 1'b0;
    end
    return r;
  endfunction

  task automatic note_failure(input string what);
    fail_count++;
    $display("mismatch: %s", what);
  endtask

  task automatic check_field(input string name, input int got, input int want);
    if (got != want)
      note_failure($sformatf("result %0d %s got %0d want %0d", results_seen, name, got, want));
  endtask

  task automatic send_byte(input logic [7:0] b, input logic last);
    pending.push_back({b, last});
  endtask

  task automatic send_text(input string s, input logic last_at_end);
    for (int i = 0; i < s.len(); i++) send_byte(s[i], last_at_end && (i == s.len() - 1));
  endtask

  // Build one scanned message, mostly well formed, sometimes noise or damaged.
  task automatic add_message();
    logic [7:0] msg [$];
    logic [7:0] ch;
    int kind, n_el, e, len, cut;
    int date_part [3];
    kind = $urandom_range(0, 99);
    if (kind < 10) begin
      len = $urandom_range(1, 6);
      repeat (len) msg.push_back(8'($urandom));
    end else if (kind < 13) begin
      len = $urandom_range(1, 3);
      repeat (len) msg.push_back(GS_BYTE);
    end else begin
      if ($urandom_range(0, 4) == 0) begin
        msg.push_back(AIM_FLAG);
        msg.push_back(8'($urandom));
        msg.push_back(8'($urandom));
      end
      n_el = $urandom_range(1, 4);
      for (e = 0; e < n_el; e++) begin
        if ($urandom_range(0, 5) == 0) msg.push_back(GS_BYTE);
        case ($urandom_range(0, 3))
          0: begin
            msg.push_back(CHAR_ZERO);
            msg.push_back(CHAR_ONE);
            repeat (int'(GTIN_DIGITS)) msg.push_back(8'(CHAR_ZERO + $urandom_range(0, 9)));
            if ($urandom_range(0, 7) == 0) msg.push_back(GS_BYTE);
          end
          1: begin
            msg.push_back(CHAR_ONE);
            msg.push_back(CHAR_SEVEN);
            date_part[0] = $urandom_range(0, 99);
            date_part[1] = ($urandom_range(0, 99) < 85) ? $urandom_range(1, 12)
                                                         : $urandom_range(0, 99);
            if ($urandom_range(0, 4) == 0) date_part[2] = 0;
            else date_part[2] = ($urandom_range(0, 99) < 85) ? $urandom_range(1, 31)
                                                              : $urandom_range(0, 99);
            for (int k = 0; k < 3; k++) begin
              msg.push_back(8'(int'(CHAR_ZERO) + date_part[k] / 10));
              msg.push_back(8'(int'(CHAR_ZERO) + date_part[k] % 10));
            end
            if ($urandom_range(0, 7) == 0) msg.push_back(GS_BYTE);
          end
          default: begin
            if ($urandom_range(0, 1) == 0) begin
              msg.push_back(CHAR_ONE);
              msg.push_back(CHAR_ZERO);
            end else begin
              msg.push_back(CHAR_TWO);
              msg.push_back(CHAR_ONE);
            end
            cut = $urandom_range(0, 99);
            if (cut < 4) len = 0;
            else if (cut < 14) len = $urandom_range(20, 21);
            else len = $urandom_range(1, 8);
            repeat (len) begin
              do ch = 8'($urandom); while (ch == GS_BYTE);
              msg.push_back(ch);
            end
            if (e < n_el - 1 || $urandom_range(0, 3) == 0) msg.push_back(GS_BYTE);
          end
        endcase
      end
      // damage some messages: overwrite a byte, or cut the tail off
      if ($urandom_range(0, 9) == 0) msg[$urandom_range(0, msg.size() - 1)] = 8'($urandom);
      if ($urandom_range(0, 9) == 0) begin
        cut = $urandom_range(1, msg.size());
        while (msg.size() > cut) void'(msg.pop_back());
      end
    end
    for (int i = 0; i < msg.size(); i++) send_byte(msg[i], i == msg.size() - 1);
  endtask

  always @(posedge clk) begin : drive_bytes
    scan_byte_t nxt;
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        parse_expect.push_back(parse_byte(in_tdata, in_tlast));
        bytes_accepted++;
        if (pending.size() > CALM_TAIL && (bytes_accepted / 100) % 3 != 2 &&
            $urandom_range(0, 99) < 25)
          send_gap = $urandom_range(1, 7);
      end
      if (in_tvalid && !in_tready) begin
        // hold the request until it is taken
      end else if (send_gap > 0) begin
        send_gap--;
        in_tvalid <= 1'b0;
      end else if (pending.size() > 0) begin
        nxt = pending.pop_front();
        in_tvalid <= 1'b1;
        in_tdata <= nxt.data;
        in_tlast <= nxt.last;
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin : watch_results
    parse_result_t want;
    logic next_ready;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        results_seen++;
        if (parse_expect.size() == 0) begin
          note_failure($sformatf("result %0d arrived with nothing pending", results_seen));
        end else begin
          want = parse_expect.pop_front();
          check_field("byte_role", int'(out_tuser), int'(want.role));
          check_field("position_in_field", int'(out_tdata[4:0]), int'(want.pos));
          check_field("done_res", int'(out_tlast), int'(want.done));
          check_field("status", int'(out_tdata[7:5]), int'(want.status));
          check_field("expiry_seen", int'(out_tdata[8]), int'(want.seen));
          check_field("expiry_valid", int'(out_tdata[9]), int'(want.valid));
          check_field("expiry_year", int'(out_tdata[21:10]), int'(want.year));
          check_field("expiry_month", int'(out_tdata[25:22]), int'(want.month));
          check_field("expiry_day", int'(out_tdata[30:26]), int'(want.day));
        end
      end
      // one long hold-off so the block backs up into its input
      if (!pressure_done && results_seen >= 400) begin
        pressure_done = 1'b1;
        recv_hold = LONG_HOLD;
      end
      if (recv_hold > 0) begin
        recv_hold--;
        next_ready = 1'b0;
      end else if (results_seen + CALM_TAIL < total_bytes && (results_seen / 100) % 3 != 1 &&
                   $urandom_range(0, 99) < 10) begin
        recv_hold = $urandom_range(1, 7) - 1;
        next_ready = 1'b0;
      end else begin
        next_ready = 1'b1;
      end
      out_tready <= next_ready;
    end
  end

  always @(posedge clk) begin : watchdog
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  initial begin
    send_byte(AIM_FLAG, 1'b1);          // prefix cut after one byte
    send_text("]d", 1'b1);              // prefix cut after two bytes
    send_byte(GS_BYTE, 1'b1);           // nothing but a separator
    send_text("17240200", 1'b1);        // day 00 in a leap February
    send_byte(8'h00, 1'b0);             // unknown AI from extreme bytes
    send_byte(8'hFF, 1'b1);
    send_text("10", 1'b0);              // empty lot field
    send_byte(GS_BYTE, 1'b1);
    send_text("21x", 1'b1);             // serial closed by message end
    send_text("01A9", 1'b1);            // bad GTIN digit, then ignored byte
    send_byte(CHAR_ONE, 1'b1);          // open AI at message end
    while (pending.size() < 1925) add_message();
    total_bytes = pending.size();

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    while (bytes_accepted < total_bytes || parse_expect.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    if (fail_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

>>> gs1_element_string_parser_core.f
+incdir+sv
sv/gsep_pkg.sv
sv/gs1_element_string_parser_core.sv
sv/gsep_checker.sv
sim/tb.sv
